### hw/rtl/highest_average_seat_allocator_unit_macros.svh
// Assertion macros for the seat allocator RTL.
`ifndef HIGHEST_AVERAGE_SEAT_ALLOCATOR_UNIT_MACROS_SVH
`define HIGHEST_AVERAGE_SEAT_ALLOCATOR_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define HASU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define HASU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/hasu_pkg.sv
// Shared constants and types for the seat allocator.
package hasu_pkg;

  localparam int MAX_PARTIES = 64;
  localparam int VOTE_W      = 24;
  localparam int SEAT_W      = 16;
  localparam int IDX_W       = 6;
  localparam int CNT_W       = 7;
  localparam int PROD_W      = VOTE_W + SEAT_W + 1;
  localparam int RAM_AW      = (MAX_PARTIES > 1) ? $clog2(MAX_PARTIES) : 1;

  // One party's quotient operands: votes and seats held so far.
  typedef struct packed {
    logic [VOTE_W-1:0] votes;
    logic [SEAT_W-1:0] seats;
  } quot_t;

endpackage

### hw/rtl/hasu_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module hasu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                         wr_data,
  input  logic                                     rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### hw/rtl/hasu_qcmp.sv
// Quotient comparator: cross-multiplies candidate and leader, registers products.
module hasu_qcmp (
  input  logic           clk,
  input  hasu_pkg::quot_t cand,
  input  hasu_pkg::quot_t lead,
  output logic           cand_wins
);

  logic [hasu_pkg::SEAT_W:0]   cand_seats_p1;
  logic [hasu_pkg::SEAT_W:0]   lead_seats_p1;
  logic [hasu_pkg::PROD_W-1:0] lhs;
  logic [hasu_pkg::PROD_W-1:0] rhs;

  assign cand_seats_p1 = {1'b0, cand.seats} + (hasu_pkg::SEAT_W+1)'(1);
  assign lead_seats_p1 = {1'b0, lead.seats} + (hasu_pkg::SEAT_W+1)'(1);

  // cand beats lead when votes_c/(s_c+1) > votes_l/(s_l+1)
  always_ff @(posedge clk) begin
    lhs <= hasu_pkg::PROD_W'(cand.votes) * hasu_pkg::PROD_W'(lead_seats_p1);
    rhs <= hasu_pkg::PROD_W'(lead.votes) * hasu_pkg::PROD_W'(cand_seats_p1);
  end

  // strict compare: a tie keeps the lower index
  assign cand_wins = lhs > rhs;

endmodule

### hw/rtl/highest_average_seat_allocator_unit.sv
// Top level: highest-average seat allocator with vote and seat memories.
//
//  channel  direction  handshake            payload
//  in       sink       in_valid / in_stall   vote_count, last_party
//  out      source     out_valid / out_stall party_index, seat_count, last_result, overflowed
//  cfg      sink       cfg_write_en          cfg_write_data (seat_total)
//
// Loading takes one party a cycle. After the last party, each seat takes a scan over the N
// parties stored: one memory read per party, a cross-multiply-then-compare pass per party
// after entry 0. Results then follow an S_EPRE read, one a cycle while out_stall is low.
// in_stall stays high from the last party until the final result is in the output register.
// Reset clears control state only; no memory clearing pass is needed.
`include "highest_average_seat_allocator_unit_macros.svh"

module highest_average_seat_allocator_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write_en,
  input  logic [hasu_pkg::SEAT_W-1:0]   cfg_write_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [hasu_pkg::VOTE_W-1:0]   vote_count,
  input  logic                          last_party,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [hasu_pkg::IDX_W-1:0]    party_index,
  output logic [hasu_pkg::SEAT_W-1:0]   seat_count,
  output logic                          last_result,
  output logic                          overflowed
);

  typedef enum logic [2:0] {
    S_LOAD,
    S_START,
    S_FIRST,
    S_MUL,
    S_CMP,
    S_AWARD,
    S_EPRE,
    S_EMIT
  } state_t;

  state_t                        state;
  logic [hasu_pkg::SEAT_W-1:0]   seat_total;
  logic [hasu_pkg::CNT_W-1:0]    party_count;
  logic                          overflow_flag;
  logic [hasu_pkg::SEAT_W-1:0]   seats_left;
  logic [hasu_pkg::IDX_W-1:0]    cur;
  logic [hasu_pkg::IDX_W-1:0]    best_idx;
  hasu_pkg::quot_t               best;

  logic                          in_xfer;
  logic                          out_free;
  logic                          has_room;
  logic [hasu_pkg::CNT_W-1:0]    last_idx;
  logic                          cur_is_last;

  logic                          rd_en;
  logic [hasu_pkg::IDX_W-1:0]    rd_addr;
  logic                          vote_we;
  logic                          seat_we;
  logic [hasu_pkg::IDX_W-1:0]    seat_waddr;
  logic [hasu_pkg::SEAT_W-1:0]   seat_wdata;
  logic [hasu_pkg::VOTE_W-1:0]   vote_rd;
  logic [hasu_pkg::SEAT_W-1:0]   seat_rd;

  hasu_pkg::quot_t               cand;
  logic                          cand_wins;

  assign in_stall    = (state != S_LOAD);
  assign in_xfer     = in_valid && !in_stall;
  assign out_free    = !out_valid || !out_stall;
  assign has_room    = (party_count != hasu_pkg::CNT_W'(hasu_pkg::MAX_PARTIES));
  assign last_idx    = party_count - hasu_pkg::CNT_W'(1);
  assign cur_is_last = ({1'b0, cur} == last_idx);

  assign cand.votes = vote_rd;
  assign cand.seats = seat_rd;

  // memory port control
  always_comb begin
    rd_en      = 1'b0;
    rd_addr    = cur;
    vote_we    = 1'b0;
    seat_we    = 1'b0;
    seat_waddr = party_count[hasu_pkg::IDX_W-1:0];
    seat_wdata = '0;
    case (state)
      S_LOAD: begin
        vote_we = in_xfer && has_room;
        seat_we = in_xfer && has_room;
      end
      S_START: begin
        rd_en   = 1'b1;
        rd_addr = '0;
      end
      S_FIRST: begin
        rd_en   = 1'b1;
        rd_addr = hasu_pkg::IDX_W'(1);
      end
      S_CMP: begin
        rd_en   = !cur_is_last;
        rd_addr = cur + hasu_pkg::IDX_W'(1);
      end
      S_AWARD: begin
        seat_we    = 1'b1;
        seat_waddr = best_idx;
        seat_wdata = best.seats + hasu_pkg::SEAT_W'(1);
      end
      S_EPRE: begin
        rd_en   = 1'b1;
        rd_addr = '0;
      end
      S_EMIT: begin
        rd_en   = out_free && !cur_is_last;
        rd_addr = cur + hasu_pkg::IDX_W'(1);
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  hasu_ram #(
    .WIDTH(hasu_pkg::VOTE_W),
    .DEPTH(hasu_pkg::MAX_PARTIES)
  ) u_vote_ram (
    .clk    (clk),
    .wr_en  (vote_we),
    .wr_addr(party_count[hasu_pkg::RAM_AW-1:0]),
    .wr_data(vote_count),
    .rd_en  (rd_en),
    .rd_addr(rd_addr[hasu_pkg::RAM_AW-1:0]),
    .rd_data(vote_rd)
  );

  hasu_ram #(
    .WIDTH(hasu_pkg::SEAT_W),
    .DEPTH(hasu_pkg::MAX_PARTIES)
  ) u_seat_ram (
    .clk    (clk),
    .wr_en  (seat_we),
    .wr_addr(seat_waddr[hasu_pkg::RAM_AW-1:0]),
    .wr_data(seat_wdata),
    .rd_en  (rd_en),
    .rd_addr(rd_addr[hasu_pkg::RAM_AW-1:0]),
    .rd_data(seat_rd)
  );

  hasu_qcmp u_qcmp (
    .clk      (clk),
    .cand     (cand),
    .lead     (best),
    .cand_wins(cand_wins)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_LOAD;
      seat_total    <= '0;
      party_count   <= '0;
      overflow_flag <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        seat_total <= cfg_write_data;
      end
      // S_EMIT reloads the output register itself on a transfer
      if (out_valid && !out_stall && state != S_EMIT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_LOAD: begin
          if (in_xfer) begin
            if (has_room) begin
              party_count <= party_count + hasu_pkg::CNT_W'(1);
            end else begin
              overflow_flag <= 1'b1;
            end
            if (last_party) begin
              seats_left <= seat_total;
              state      <= (seat_total == '0) ? S_EPRE : S_START;
            end
          end
        end
        S_START: begin
          state <= S_FIRST;
        end
        S_FIRST: begin
          // entry 0 leads until beaten
          best     <= cand;
          best_idx <= '0;
          cur      <= hasu_pkg::IDX_W'(1);
          state    <= (party_count == hasu_pkg::CNT_W'(1)) ? S_AWARD : S_MUL;
        end
        S_MUL: begin
          state <= S_CMP;
        end
        S_CMP: begin
          if (cand_wins) begin
            best     <= cand;
            best_idx <= cur;
          end
          if (cur_is_last) begin
            state <= S_AWARD;
          end else begin
            cur   <= cur + hasu_pkg::IDX_W'(1);
            state <= S_MUL;
          end
        end
        S_AWARD: begin
          seats_left <= seats_left - hasu_pkg::SEAT_W'(1);
          state      <= (seats_left == hasu_pkg::SEAT_W'(1)) ? S_EPRE : S_START;
        end
        S_EPRE: begin
          cur   <= '0;
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            party_index <= cur;
            seat_count  <= seat_rd;
            last_result <= cur_is_last;
            overflowed  <= overflow_flag;
            if (cur_is_last) begin
              // close the election; the last result waits in the output register
              party_count   <= '0;
              overflow_flag <= 1'b0;
              state         <= S_LOAD;
            end else begin
              cur <= cur + hasu_pkg::IDX_W'(1);
            end
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  `HASU_ASSERT_IMP(a_count_bound, 1'b1, party_count <= hasu_pkg::CNT_W'(hasu_pkg::MAX_PARTIES), "party count beyond capacity")
  `HASU_ASSERT_IMP(a_scan_in_range, state == S_CMP || state == S_EMIT, {1'b0, cur} < party_count, "scan index beyond stored parties")
  `HASU_ASSERT_IMP(a_award_in_range, state == S_AWARD, {1'b0, best_idx} < party_count, "seat awarded to unstored party")
  `HASU_ASSERT_NXT(a_close_stalls, in_xfer && last_party, in_stall, "input not stalled after last party")
  `HASU_ASSERT_NXT(a_last_reopens, out_free && state == S_EMIT && cur_is_last, out_valid && last_result && !in_stall, "final result not loaded on close")

endmodule

### test/tb.sv
// Self-checking testbench for the highest-average seat allocator unit.
module tb;
  import hasu_pkg::*;

  localparam int unsigned RANDOM_PARTIES = 260;
  localparam int unsigned IDLE_PAUSE     = 4;
  localparam int unsigned DRAIN_CYCLES   = 32;
  localparam int unsigned LIMIT_CYCLES   = 4_000_000;

  typedef struct {
    logic [IDX_W-1:0]  party;
    logic [SEAT_W-1:0] seats;
    logic              closing;
    logic              dropped;
  } seat_result_t;

  logic                clk = 1'b0;
  logic                rst;
  logic                cfg_write_en;
  logic [SEAT_W-1:0]   cfg_write_data;
  logic                in_valid;
  logic                in_stall;
  logic [VOTE_W-1:0]   vote_count;
  logic                last_party;
  logic                out_valid;
  logic                out_stall;
  logic [IDX_W-1:0]    party_index;
  logic [SEAT_W-1:0]   seat_count;
  logic                last_result;
  logic                overflowed;

  // Local copy of the allocator state
  logic [SEAT_W-1:0]   seats_cfg;
  logic [VOTE_W-1:0]   votes_held [MAX_PARTIES];
  logic [SEAT_W-1:0]   seats_won  [MAX_PARTIES];
  int unsigned         parties_held;
  bit                  parties_dropped;

  seat_result_t        seat_results_q[$];
  int unsigned         mismatches;
  int unsigned         parties_sent;
  int unsigned         cycles_run;
  bit                  fast_in;
  bit                  fast_out;

  highest_average_seat_allocator_unit u_top (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .vote_count     (vote_count),
    .last_party     (last_party),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .party_index    (party_index),
    .seat_count     (seat_count),
    .last_result    (last_result),
    .overflowed     (overflowed)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Store one party; on the closing party run the whole allocation and queue its results.
  function automatic void tally_party(input logic [VOTE_W-1:0] votes, input logic closing);
    int unsigned best;
    logic [63:0] lhs;
    logic [63:0] rhs;
    if (parties_held < MAX_PARTIES) begin
      votes_held[parties_held] = votes;
      seats_won[parties_held]  = '0;
      parties_held++;
    end else begin
      parties_dropped = 1'b1;
    end
    if (!closing) return;
    for (int unsigned s = 0; s < seats_cfg; s++) begin
      best = 0;
      for (int unsigned i = 1; i < parties_held; i++) begin
        lhs = 64'(votes_held[i]) * (64'(seats_won[best]) + 64'd1);
        rhs = 64'(votes_held[best]) * (64'(seats_won[i]) + 64'd1);
        if (lhs > rhs) best = i;
      end
      seats_won[best] = seats_won[best] + 1'b1;
    end
    for (int unsigned i = 0; i < parties_held; i++) begin
      seat_results_q.push_back('{party:   IDX_W'(i),
                                 seats:   seats_won[i],
                                 closing: (i + 1 == parties_held),
                                 dropped: parties_dropped});
    end
    for (int unsigned i = 0; i < MAX_PARTIES; i++) seats_won[i] = '0;
    parties_held    = 0;
    parties_dropped = 1'b0;
  endfunction

  // Vote mix: extremes, small counts, repeats, single-bit flips, doublings for quotient ties, random.
  function automatic logic [VOTE_W-1:0] draw_votes(input logic [VOTE_W-1:0] prev);
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return VOTE_W'($urandom_range(0, 15));
      3: return prev;
      4: return prev ^ VOTE_W'(1 << $urandom_range(0, VOTE_W - 1));
      5: return {prev[VOTE_W-2:0], 1'b0};
      default: return VOTE_W'($urandom);
    endcase
  endfunction

  task automatic send_party(input logic [VOTE_W-1:0] votes, input logic closing);
    int unsigned gap;
    gap = fast_in ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      in_valid   <= 1'b0;
      vote_count <= VOTE_W'($urandom);
      last_party <= 1'($urandom);
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    vote_count <= votes;
    last_party <= closing;
    do @(posedge clk); while (in_stall);
    tally_party(votes, closing);
    parties_sent++;
  endtask

  // Write the register only once every result is out and the block has settled.
  task automatic set_seats(input logic [SEAT_W-1:0] seats);
    in_valid <= 1'b0;
    while (seat_results_q.size() != 0) @(posedge clk);
    repeat (IDLE_PAUSE) @(posedge clk);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= seats;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    seats_cfg = seats;
  endtask

  task automatic test_zero_seats();
    set_seats('0);
    send_party('1, 1'b0);
    send_party('0, 1'b0);
    send_party(VOTE_W'(1), 1'b1);
    send_party(VOTE_W'(24'h123456), 1'b1);
  endtask

  task automatic test_equal_quotients();
    set_seats(SEAT_W'(7));
    send_party('0, 1'b0);
    send_party('0, 1'b0);
    send_party('0, 1'b1);
    // 20/2 against 10/1 ties: the lower index must take the seat
    set_seats(SEAT_W'(6));
    send_party(VOTE_W'(10), 1'b0);
    send_party(VOTE_W'(20), 1'b0);
    send_party(VOTE_W'(10), 1'b0);
    send_party(VOTE_W'(20), 1'b1);
  endtask

  task automatic test_extreme_votes();
    set_seats('1);
    send_party('1, 1'b1);
    set_seats(SEAT_W'(1000));
    send_party('1, 1'b0);
    send_party(VOTE_W'(24'hFFFFFE), 1'b0);
    send_party('1, 1'b0);
    send_party(VOTE_W'(1), 1'b0);
    send_party('0, 1'b1);
  endtask

  task automatic test_capacity();
    logic [VOTE_W-1:0] votes;
    votes = VOTE_W'($urandom);
    set_seats(SEAT_W'(100));
    for (int unsigned k = 0; k < MAX_PARTIES; k++) begin
      votes = draw_votes(votes);
      send_party(votes, k == MAX_PARTIES - 1);
    end
    // three parties beyond capacity, the closing one among them
    set_seats(SEAT_W'(37));
    for (int unsigned k = 0; k < MAX_PARTIES + 3; k++) begin
      votes = draw_votes(votes);
      send_party(votes, k == MAX_PARTIES + 2);
    end
  endtask

  task automatic test_random_elections();
    logic [SEAT_W-1:0] seats;
    logic [VOTE_W-1:0] votes;
    int unsigned       size;
    int unsigned       pick;
    bit                heavy;
    votes = VOTE_W'($urandom);
    while (parties_sent < RANDOM_PARTIES) begin
      heavy = ($urandom_range(0, 9) == 0);
      seats = heavy ? SEAT_W'($urandom_range(65, 400)) : SEAT_W'($urandom_range(0, 48));
      set_seats(seats);
      repeat ($urandom_range(1, 4)) begin
        pick = $urandom_range(0, 19);
        // keep long seat runs to few parties
        if (heavy || pick < 16) size = $urandom_range(1, 6);
        else if (pick < 19)     size = $urandom_range(7, MAX_PARTIES);
        else                    size = $urandom_range(MAX_PARTIES + 1, MAX_PARTIES + 6);
        fast_in  = ($urandom_range(0, 3) == 0);
        fast_out = ($urandom_range(0, 3) == 0);
        for (int unsigned k = 0; k < size; k++) begin
          votes = draw_votes(votes);
          send_party(votes, k == size - 1);
        end
      end
    end
  endtask

  initial begin
    rst            <= 1'b1;
    cfg_write_en   <= 1'b0;
    cfg_write_data <= '0;
    in_valid       <= 1'b0;
    vote_count     <= '0;
    last_party     <= 1'b0;
    seats_cfg       = '0;
    parties_held    = 0;
    parties_dropped = 1'b0;
    parties_sent    = 0;
    mismatches      = 0;
    fast_in         = 1'b0;
    fast_out        = 1'b0;
    for (int unsigned i = 0; i < MAX_PARTIES; i++) seats_won[i] = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_zero_seats();
    test_equal_quotients();
    test_extreme_votes();
    test_capacity();
    test_random_elections();

    in_valid <= 1'b0;
    while (seat_results_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("PASS highest_average_seat_allocator_unit");
    else $display("FAIL highest_average_seat_allocator_unit");
    $finish;
  end

  // Result side back-pressure: a fresh hold-off before each transfer.
  initial begin : result_stall
    int unsigned hold;
    out_stall <= 1'b1;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      hold = fast_out ? 0 : $urandom_range(0, 12);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin : check_result
    seat_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (seat_results_q.size() == 0) begin
        $error("unexpected result: party_index %0d seat_count %0d", party_index, seat_count);
        mismatches++;
      end else begin
        want = seat_results_q.pop_front();
        if (party_index !== want.party) begin
          $error("party_index: expected %0d, got %0d", want.party, party_index);
          mismatches++;
        end
        if (seat_count !== want.seats) begin
          $error("seat_count: expected %0d, got %0d", want.seats, seat_count);
          mismatches++;
        end
        if (last_result !== want.closing) begin
          $error("last_result: expected %0b, got %0b", want.closing, last_result);
          mismatches++;
        end
        if (overflowed !== want.dropped) begin
          $error("overflowed: expected %0b, got %0b", want.dropped, overflowed);
          mismatches++;
        end
      end
    end
  end

  initial begin : watchdog
    cycles_run = 0;
    while (cycles_run < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles_run++;
    end
    $display("FAIL highest_average_seat_allocator_unit");
    $finish;
  end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/hasu_pkg.sv
hw/rtl/hasu_ram.sv
hw/rtl/hasu_qcmp.sv
hw/rtl/highest_average_seat_allocator_unit.sv
test/tb.sv
